// File: rtl/pne_pkg.sv
// Shared types and constants of the point normal estimator.
// Depends on nothing; used by the controller, the datapath and the top level.
`default_nettype none
package pne_pkg;

  localparam int unsigned MAXD_W     = 17;
  localparam logic [MAXD_W-1:0] MAXD_RESET = 17'd80000;
  localparam int unsigned NRM_W      = 16;
  localparam int unsigned Q_W        = 16;
  localparam logic [Q_W-1:0] UNIT_Q14 = 16'd16384;
  localparam int unsigned MUL_W      = 32;
  localparam int unsigned SUM_W      = 62;
  localparam int unsigned ROOT_W     = 63;
  localparam int unsigned LEN_W      = 32;
  localparam int unsigned NMAG_W     = 30;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned ROOT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 16;
  localparam int unsigned CROSS_OPS  = 6;
  localparam int unsigned SQ_OPS     = 3;

  // product selects: six cross terms, then three squares
  localparam logic [3:0] SEL_SQ0 = 4'd6;

  typedef struct packed {
    logic       load;
    logic       diff;
    logic       mul;
    logic [3:0] mul_sel;
    logic       norm;
    logic       root_init;
    logic       root_step;
    logic       div_init;
    logic       div_step;
    logic       div_fin;
    logic       emit_mid;
    logic       emit_end;
    logic       shift_win;
  } pne_cmd_t;

  typedef struct packed {
    logic [1:0] held;
    logic       mid_inr;
    logic       eoc;
    logic       m_zero;
    logic       norm_done;
    logic       out_free;
  } pne_sts_t;

endpackage
`default_nettype wire

// File: rtl/pne_datapath.sv
// Datapath: point window, shared multiplier, normalizer, square root and dividers.
// Depends on pne_pkg; driven by pne_controller.
`default_nettype none
module pne_datapath import pne_pkg::*; #(
  parameter int unsigned CW = 18
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire pne_cmd_t             cmd_i,
  output pne_sts_t                  sts_o,
  input  wire logic signed [CW-1:0] coord_x_i,
  input  wire logic signed [CW-1:0] coord_y_i,
  input  wire logic signed [CW-1:0] coord_z_i,
  input  wire logic                 end_of_cloud_i,
  input  wire logic                 max_distance_we_i,
  input  wire logic [MAXD_W-1:0]    max_distance_i,
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  output logic signed [NRM_W-1:0]   normal_x_o,
  output logic signed [NRM_W-1:0]   normal_y_o,
  output logic signed [NRM_W-1:0]   normal_z_o,
  output logic                      in_range_o,
  output logic                      has_neighbours_o,
  output logic                      last_result_o
);

  localparam int unsigned PRE_SHIFT = (CW > 30) ? CW - 30 : 0;
  localparam int unsigned DW        = CW + 1 - PRE_SHIFT;
  localparam int unsigned NMW       = (2 * DW > 31) ? 2 * DW : 31;
  localparam int unsigned CMPW      = (CW > MAXD_W) ? CW : MAXD_W;

  logic [MAXD_W-1:0] maxd_q;
  logic signed [CW-1:0] old_q [3];
  logic signed [CW-1:0] mid_q [3];
  logic signed [CW-1:0] new_q [3];
  logic [1:0] held_q;
  logic new_inr_q, eoc_q;
  logic signed [DW-1:0] a_q [3];
  logic signed [DW-1:0] b_q [3];
  logic signed [2*MUL_W-1:0] prod_q, acc_q;
  logic [3:0] psel_q;
  logic pvld_q;
  logic [NMW-1:0] mag_q [3];
  logic [2:0] neg_q;
  logic [SUM_W-1:0] sum_q;
  logic [ROOT_W-1:0] rn_q, res_q, bit_q;
  logic [LEN_W-1:0] len_q;
  logic [LEN_W:0] rem_q [3];
  logic [Q_W-1:0] qn_q [3];
  logic signed [NRM_W-1:0] nrm_q [3];

  logic in_inr, mid_inr;
  logic signed [MUL_W-1:0] opa, opb;
  logic signed [2*MUL_W-1:0] dcr;
  logic [NMW-1:0] dmag, mx01, m;
  logic [ROOT_W-1:0] rt;

  function automatic logic pt_inr(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                  logic signed [CW-1:0] z, logic [MAXD_W-1:0] lim);
    logic [CMPW-1:0] ux, uy, uz, um;
    ux = CMPW'(x[CW-1:0]);
    uy = CMPW'(y[CW-1:0]);
    uz = CMPW'(z[CW-1:0]);
    um = CMPW'(lim);
    return !x[CW-1] && !y[CW-1] && !z[CW-1] && (ux <= um) && (uy <= um) && (uz <= um);
  endfunction

  assign in_inr  = pt_inr(coord_x_i, coord_y_i, coord_z_i, maxd_q);
  assign mid_inr = pt_inr(mid_q[0], mid_q[1], mid_q[2], maxd_q);

  always_comb begin
    opa = '0;
    opb = '0;
    case (cmd_i.mul_sel)
      4'd0: begin opa = MUL_W'(a_q[1]); opb = MUL_W'(b_q[2]); end
      4'd1: begin opa = MUL_W'(a_q[2]); opb = MUL_W'(b_q[1]); end
      4'd2: begin opa = MUL_W'(a_q[2]); opb = MUL_W'(b_q[0]); end
      4'd3: begin opa = MUL_W'(a_q[0]); opb = MUL_W'(b_q[2]); end
      4'd4: begin opa = MUL_W'(a_q[0]); opb = MUL_W'(b_q[1]); end
      4'd5: begin opa = MUL_W'(a_q[1]); opb = MUL_W'(b_q[0]); end
      4'd6: begin opa = MUL_W'(mag_q[0][NMAG_W-1:0]); opb = opa; end
      4'd7: begin opa = MUL_W'(mag_q[1][NMAG_W-1:0]); opb = opa; end
      4'd8: begin opa = MUL_W'(mag_q[2][NMAG_W-1:0]); opb = opa; end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  assign dcr  = acc_q - prod_q;
  assign dmag = NMW'(dcr[2*MUL_W-1] ? -dcr : dcr);
  assign mx01 = (mag_q[0] > mag_q[1]) ? mag_q[0] : mag_q[1];
  assign m    = (mx01 > mag_q[2]) ? mx01 : mag_q[2];
  assign rt   = res_q + bit_q;

  assign sts_o.held      = held_q;
  assign sts_o.mid_inr   = mid_inr;
  assign sts_o.eoc       = eoc_q;
  assign sts_o.m_zero    = (m == '0);
  assign sts_o.norm_done = ((m >> 30) == '0) && m[29];
  assign sts_o.out_free  = !out_valid_o || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxd_q      <= MAXD_RESET;
      held_q      <= 2'd0;
      pvld_q      <= 1'b0;
      out_valid_o <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        old_q[i] <= '0;
        mid_q[i] <= '0;
      end
    end else begin
      if (max_distance_we_i) maxd_q <= max_distance_i;
      if (cmd_i.emit_mid || cmd_i.emit_end) out_valid_o <= 1'b1;
      else if (out_valid_o && out_ready_i)  out_valid_o <= 1'b0;
      pvld_q <= cmd_i.mul;
      psel_q <= cmd_i.mul_sel;
      if (cmd_i.mul) prod_q <= opa * opb;
      if (cmd_i.load) begin
        new_q[0]  <= coord_x_i;
        new_q[1]  <= coord_y_i;
        new_q[2]  <= coord_z_i;
        new_inr_q <= in_inr;
        eoc_q     <= end_of_cloud_i;
        for (int i = 0; i < 3; i++) begin
          nrm_q[i] <= '0;
          mag_q[i] <= '0;
        end
      end
      if (cmd_i.diff) begin
        for (int i = 0; i < 3; i++) begin
          a_q[i] <= DW'(($signed({new_q[i][CW-1], new_q[i]}) -
                         $signed({old_q[i][CW-1], old_q[i]})) >>> PRE_SHIFT);
          b_q[i] <= DW'(($signed({mid_q[i][CW-1], mid_q[i]}) -
                         $signed({old_q[i][CW-1], old_q[i]})) >>> PRE_SHIFT);
        end
      end
      if (pvld_q) begin
        case (psel_q)
          4'd0, 4'd2, 4'd4: acc_q <= prod_q;
          4'd1: begin mag_q[0] <= dmag; neg_q[0] <= dcr[2*MUL_W-1]; end
          4'd3: begin mag_q[1] <= dmag; neg_q[1] <= dcr[2*MUL_W-1]; end
          4'd5: begin mag_q[2] <= dmag; neg_q[2] <= dcr[2*MUL_W-1]; end
          4'd6: sum_q <= prod_q[SUM_W-1:0];
          4'd7, 4'd8: sum_q <= sum_q + prod_q[SUM_W-1:0];
          default: acc_q <= acc_q;
        endcase
      end
      if (cmd_i.norm) begin
        for (int i = 0; i < 3; i++) begin
          if ((m >> 34) != '0)      mag_q[i] <= mag_q[i] >> 4;
          else if ((m >> 30) != '0) mag_q[i] <= mag_q[i] >> 1;
          else if ((m >> 26) == '0) mag_q[i] <= mag_q[i] << 4;
          else                      mag_q[i] <= mag_q[i] << 1;
        end
      end
      if (cmd_i.root_init) begin
        rn_q  <= ROOT_W'(sum_q);
        res_q <= '0;
        bit_q <= ROOT_W'(1) << (ROOT_W - 1);
      end
      if (cmd_i.root_step) begin
        if (rn_q >= rt) begin
          rn_q  <= rn_q - rt;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      if (cmd_i.div_init) len_q <= res_q[LEN_W-1:0];
      for (int i = 0; i < 3; i++) begin
        logic [NMAG_W+Q_W-1:0] num;
        logic [LEN_W:0] r2;
        num = {2'b00, mag_q[i][NMAG_W-1:0], 14'd0} + (NMAG_W+Q_W)'(res_q[LEN_W-1:1]);
        r2  = {rem_q[i][LEN_W-1:0], qn_q[i][Q_W-1]};
        if (cmd_i.div_init) begin
          rem_q[i] <= (LEN_W+1)'(num[NMAG_W+Q_W-1:Q_W]);
          qn_q[i]  <= num[Q_W-1:0];
        end
        if (cmd_i.div_step) begin
          if (r2 >= {1'b0, len_q}) rem_q[i] <= r2 - {1'b0, len_q};
          else                     rem_q[i] <= r2;
          qn_q[i] <= {qn_q[i][Q_W-2:0], r2 >= {1'b0, len_q}};
        end
        if (cmd_i.div_fin) begin
          if (qn_q[i] > UNIT_Q14)
            nrm_q[i] <= neg_q[i] ? -$signed(UNIT_Q14) : $signed(UNIT_Q14);
          else
            nrm_q[i] <= neg_q[i] ? -$signed(qn_q[i]) : $signed(qn_q[i]);
        end
      end
      if (cmd_i.emit_mid) begin
        normal_x_o       <= nrm_q[0];
        normal_y_o       <= nrm_q[1];
        normal_z_o       <= nrm_q[2];
        in_range_o       <= mid_inr;
        has_neighbours_o <= (held_q == 2'd2);
        last_result_o    <= 1'b0;
      end
      if (cmd_i.emit_end) begin
        normal_x_o       <= '0;
        normal_y_o       <= '0;
        normal_z_o       <= '0;
        in_range_o       <= new_inr_q;
        has_neighbours_o <= 1'b0;
        last_result_o    <= 1'b1;
      end
      if (cmd_i.shift_win) begin
        if (eoc_q) begin
          held_q <= 2'd0;
        end else begin
          if (held_q != 2'd0) begin
            old_q  <= mid_q;
            held_q <= 2'd2;
          end else begin
            held_q <= 2'd1;
          end
          mid_q <= new_q;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/pne_controller.sv
// Sequencer of the point normal estimator: steps the datapath through one request.
// Depends on pne_pkg; commands pne_datapath.
`default_nettype none
module pne_controller import pne_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire pne_sts_t sts_i,
  output pne_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_MUL, S_NORM, S_SQR, S_ROOT, S_DIV,
    S_EMIT_MID, S_EMIT_END, S_SHIFT
  } state_e;

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q + 1'b1;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.held == 2'd0)
            state_d = S_SHIFT;
          else if (sts_i.held == 2'd2 && sts_i.mid_inr)
            state_d = S_DIFF;
          else
            state_d = S_EMIT_MID;
        end
      end
      S_DIFF: begin
        cmd_o.diff = 1'b1;
        cnt_d      = '0;
        state_d    = S_MUL;
      end
      S_MUL: begin
        if (cnt_q < CNT_W'(CROSS_OPS)) begin
          cmd_o.mul     = 1'b1;
          cmd_o.mul_sel = cnt_q[3:0];
        end else begin
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        cnt_d = '0;
        if (sts_i.m_zero)         state_d = S_EMIT_MID;
        else if (sts_i.norm_done) state_d = S_SQR;
        else                      cmd_o.norm = 1'b1;
      end
      S_SQR: begin
        if (cnt_q < CNT_W'(SQ_OPS)) begin
          cmd_o.mul     = 1'b1;
          cmd_o.mul_sel = SEL_SQ0 + cnt_q[3:0];
        end else begin
          cnt_d   = '0;
          state_d = S_ROOT;
        end
      end
      S_ROOT: begin
        if (cnt_q == '0) cmd_o.root_init = 1'b1;
        else             cmd_o.root_step = 1'b1;
        if (cnt_q == CNT_W'(ROOT_STEPS)) begin
          cnt_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (cnt_q == '0)                        cmd_o.div_init = 1'b1;
        else if (cnt_q <= CNT_W'(DIV_STEPS))    cmd_o.div_step = 1'b1;
        else begin
          cmd_o.div_fin = 1'b1;
          state_d       = S_EMIT_MID;
        end
      end
      S_EMIT_MID: begin
        if (sts_i.out_free) begin
          cmd_o.emit_mid = 1'b1;
          state_d        = sts_i.eoc ? S_EMIT_END : S_SHIFT;
        end
      end
      S_EMIT_END: begin
        if (sts_i.out_free) begin
          cmd_o.emit_end  = 1'b1;
          cmd_o.shift_win = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_SHIFT: begin
        if (sts_i.eoc) begin
          state_d = S_EMIT_END;
        end else begin
          cmd_o.shift_win = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/point_normal_estimator_unit.sv
// Top level of the point normal estimator: controller plus datapath.
// Depends on pne_pkg, pne_controller and pne_datapath.
//
//   port group          handshake                   payload
//   input points        in_valid_i / in_ready_o     coord_x/y/z_i, end_of_cloud_i
//   result normals      out_valid_o / out_ready_i   normal_x/y/z_o, flags
//   max_distance        max_distance_we_i           max_distance_i
//
// One request at a time. An endpoint or out-of-range request skips the arithmetic, and
// collinear points stop after the cross product. The work on a point with neighbours is set by
// the 32-step bit-serial square root, the 16-step dividers and a normalizer of up to 8 steps.
// Results wait in an output register; a stalled output holds the sequencer in emit.
// Reset clears the window and loads max_distance with 80000.
`default_nettype none
module point_normal_estimator_unit import pne_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 18
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [COORD_WIDTH-1:0] coord_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] coord_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] coord_z_i,
  input  wire logic                          end_of_cloud_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [NRM_W-1:0]            normal_x_o,
  output logic signed [NRM_W-1:0]            normal_y_o,
  output logic signed [NRM_W-1:0]            normal_z_o,
  output logic                               in_range_o,
  output logic                               has_neighbours_o,
  output logic                               last_result_o,
  input  wire logic                          max_distance_we_i,
  input  wire logic [MAXD_W-1:0]             max_distance_i
);

  pne_cmd_t cmd;
  pne_sts_t sts;

  pne_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pne_datapath #(.CW(COORD_WIDTH)) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .coord_x_i         (coord_x_i),
    .coord_y_i         (coord_y_i),
    .coord_z_i         (coord_z_i),
    .end_of_cloud_i    (end_of_cloud_i),
    .max_distance_we_i (max_distance_we_i),
    .max_distance_i    (max_distance_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .normal_x_o        (normal_x_o),
    .normal_y_o        (normal_y_o),
    .normal_z_o        (normal_z_o),
    .in_range_o        (in_range_o),
    .has_neighbours_o  (has_neighbours_o),
    .last_result_o     (last_result_o)
  );

endmodule
`default_nettype wire

// File: rtl/pne_checker.sv
// Port-level checks of the point normal estimator, bound to the top level.
// Depends on pne_pkg and point_normal_estimator_unit.
`default_nettype none
module pne_checker import pne_pkg::*; (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid_i,
  input wire logic                    in_ready_o,
  input wire logic                    out_valid_o,
  input wire logic                    out_ready_i,
  input wire logic signed [NRM_W-1:0] normal_x_o,
  input wire logic signed [NRM_W-1:0] normal_y_o,
  input wire logic signed [NRM_W-1:0] normal_z_o,
  input wire logic                    in_range_o,
  input wire logic                    has_neighbours_o,
  input wire logic                    last_result_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(normal_x_o) &&
    $stable(normal_y_o) && $stable(normal_z_o) && $stable(last_result_o))
    else $error("result changed while stalled");

  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  a_endpoint_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_neighbours_o |->
    normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0)
    else $error("endpoint with nonzero normal");

  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_range_o |->
    normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0)
    else $error("out-of-range point with nonzero normal");

  a_last_endpoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_result_o |-> !has_neighbours_o)
    else $error("last result claims neighbours");

endmodule

bind point_normal_estimator_unit pne_checker u_pne_checker (.*);
`default_nettype wire

// File: sim/tb.sv
// Testbench of point_normal_estimator_unit: directed table plus random point clouds.
// Depends on pne_pkg and the RTL; predicts normals in-line and checks every result.
`timescale 1ns / 100ps
`default_nettype none
module tb import pne_pkg::*;;

  localparam int unsigned CW = 18;
  localparam int unsigned N_DIR = 22;

  typedef struct packed {
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
    logic inr;
    logic nb;
    logic last;
  } normal_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic eoc;
  } point_t;

  typedef struct {
    point_t  pt;
    logic    chk;
    normal_t res;
  } row_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, maxd_we;
  logic signed [CW-1:0] cx, cy, cz;
  logic eoc;
  logic [MAXD_W-1:0] maxd;
  logic signed [NRM_W-1:0] onx, ony, onz;
  logic oinr, onb, olast;

  normal_t normal_q[$];
  normal_t typed_q[$];
  logic    typed_v[$];
  int errors, n_items, n_results, idle_cyc;
  int snd_idle, rcv_idle, hold_off;
  logic [MAXD_W-1:0] cur_maxd;
  point_t older_pt, mid_pt;
  int held;

  point_normal_estimator_unit #(.COORD_WIDTH(CW)) uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .coord_x_i(cx), .coord_y_i(cy), .coord_z_i(cz), .end_of_cloud_i(eoc),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .normal_x_o(onx), .normal_y_o(ony), .normal_z_o(onz),
    .in_range_o(oinr), .has_neighbours_o(onb), .last_result_o(olast),
    .max_distance_we_i(maxd_we), .max_distance_i(maxd)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  function automatic logic pt_in_range(point_t p);
    return p.x >= 0 && p.y >= 0 && p.z >= 0 && 64'(p.x) <= cur_maxd
        && 64'(p.y) <= cur_maxd && 64'(p.z) <= cur_maxd;
  endfunction

  function automatic logic [63:0] root64(logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else r = r >> 1;
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic normal_t normal_of(point_t p, point_t prv, point_t nxt, logic nb);
    normal_t o;
    longint a[3], b[3], cr[3];
    logic [63:0] mag[3], m, sum, len, q;
    int bl;
    o = '0;
    o.inr = pt_in_range(p);
    o.nb = nb;
    if (!(o.inr && nb)) return o;
    a[0] = nxt.x - prv.x; a[1] = nxt.y - prv.y; a[2] = nxt.z - prv.z;
    b[0] = p.x - prv.x; b[1] = p.y - prv.y; b[2] = p.z - prv.z;
    cr[0] = a[1] * b[2] - a[2] * b[1];
    cr[1] = a[2] * b[0] - a[0] * b[2];
    cr[2] = a[0] * b[1] - a[1] * b[0];
    m = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = cr[i] < 0 ? -cr[i] : cr[i];
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) return o;
    bl = 0;
    while (bl < 64 && (m >> bl) != 0) bl++;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      if (bl > 30) mag[i] = mag[i] >> (bl - 30);
      else mag[i] = mag[i] << (30 - bl);
      sum += mag[i] * mag[i];
    end
    len = root64(sum);
    if (len == 0) return o;
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] * 64'd16384 + (len >> 1)) / len;
      if (q > 16384) q = 16384;
      if (i == 0) o.nx = cr[i] < 0 ? -q[15:0] : q[15:0];
      if (i == 1) o.ny = cr[i] < 0 ? -q[15:0] : q[15:0];
      if (i == 2) o.nz = cr[i] < 0 ? -q[15:0] : q[15:0];
    end
    return o;
  endfunction

  function automatic void track_point(point_t p);
    if (held == 1) normal_q.push_back(normal_of(mid_pt, mid_pt, mid_pt, 1'b0));
    else if (held >= 2) normal_q.push_back(normal_of(mid_pt, older_pt, p, 1'b1));
    if (p.eoc) begin
      normal_q.push_back(normal_of(p, p, p, 1'b0));
      normal_q[$].last = 1'b1;
      held = 0;
    end else begin
      if (held >= 1) begin
        older_pt = mid_pt;
        held = 2;
      end else held = 1;
      mid_pt = p;
    end
  endfunction

  task automatic send(point_t p);
    while (snd_idle > 0 && $urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {cx, cy, cz, eoc} <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_point(p);
    n_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (normal_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_maxd(logic [MAXD_W-1:0] v);
    drain();
    maxd_we <= 1'b1;
    maxd <= v;
    @(posedge clk);
    maxd_we <= 1'b0;
    cur_maxd = v;
  endtask

  function automatic logic signed [CW-1:0] rnd_coord(logic [MAXD_W-1:0] lim);
    case ($urandom_range(9))
      0: return CW'($urandom);
      1: return -CW'($urandom_range(50));
      2: return CW'(32'(lim) + $urandom_range(3));
      default: return CW'($urandom_range(lim));
    endcase
  endfunction

  always @(posedge clk) begin
    normal_t e;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (normal_q.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        e = normal_q.pop_front();
        if (typed_v.size() != 0) begin
          if (typed_v.pop_front() && typed_q[0] != e) begin
            $error("typed row disagrees with prediction");
            errors++;
          end
          void'(typed_q.pop_front());
        end
        if (onx != e.nx) begin $error("normal_x exp %0d got %0d", e.nx, onx); errors++; end
        if (ony != e.ny) begin $error("normal_y exp %0d got %0d", e.ny, ony); errors++; end
        if (onz != e.nz) begin $error("normal_z exp %0d got %0d", e.nz, onz); errors++; end
        if (oinr != e.inr) begin $error("in_range exp %0d got %0d", e.inr, oinr); errors++; end
        if (onb != e.nb) begin $error("has_neighbours exp %0d got %0d", e.nb, onb); errors++; end
        if (olast != e.last) begin
          $error("last_result exp %0d got %0d", e.last, olast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else out_ready <= !(rcv_idle > 0 && $urandom_range(99) < rcv_idle);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc > 20000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    row_t rows[N_DIR];
    point_t p;
    int len;
    logic [MAXD_W-1:0] lims[4];
    errors = 0; n_items = 0; n_results = 0; idle_cyc = 0;
    snd_idle = 0; rcv_idle = 0; hold_off = 0; held = 0;
    older_pt = '0; mid_pt = '0; cur_maxd = MAXD_RESET;
    rst_n = 1'b0; in_valid = 1'b0; out_ready = 1'b0;
    cx = '0; cy = '0; cz = '0; eoc = 1'b0; maxd_we = 1'b0; maxd = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    rows[0] = '{'{18'sd0, 18'sd0, 18'sd0, 1'b1}, 1'b1, '{0, 0, 0, 1, 0, 1}};
    rows[1] = '{'{-18'sd131072, 18'sd0, 18'sd0, 1'b1}, 1'b1, '{0, 0, 0, 0, 0, 1}};
    rows[2] = '{'{18'sd131071, 18'sd131071, 18'sd131071, 1'b1}, 1'b1, '{0, 0, 0, 0, 0, 1}};
    rows[3] = '{'{18'sd0, 18'sd0, 18'sd0, 1'b0}, 1'b0, '0};
    rows[4] = '{'{18'sd1000, 18'sd0, 18'sd0, 1'b0}, 1'b1, '{0, 0, 0, 1, 0, 0}};
    rows[5] = '{'{18'sd0, 18'sd1000, 18'sd0, 1'b0}, 1'b1, '{0, 0, -16384, 1, 1, 0}};
    rows[6] = '{'{18'sd0, 18'sd0, 18'sd1000, 1'b1}, 1'b0, '0};
    rows[7] = '{'{18'sd10, 18'sd10, 18'sd10, 1'b0}, 1'b0, '0};
    rows[8] = '{'{18'sd20, 18'sd20, 18'sd20, 1'b0}, 1'b0, '0};
    rows[9] = '{'{18'sd30, 18'sd30, 18'sd30, 1'b1}, 1'b0, '0};
    rows[10] = '{'{18'sd5, 18'sd5, 18'sd5, 1'b0}, 1'b0, '0};
    rows[11] = '{'{18'sd5, 18'sd5, 18'sd5, 1'b0}, 1'b0, '0};
    rows[12] = '{'{18'sd5, 18'sd5, 18'sd5, 1'b1}, 1'b0, '0};
    rows[13] = '{'{-18'sd131072, 18'sd131071, -18'sd131072, 1'b0}, 1'b0, '0};
    rows[14] = '{'{18'sd80000, 18'sd0, 18'sd80000, 1'b0}, 1'b0, '0};
    rows[15] = '{'{18'sd131071, -18'sd131072, 18'sd131071, 1'b0}, 1'b0, '0};
    rows[16] = '{'{18'sd80001, 18'sd3, 18'sd7, 1'b0}, 1'b0, '0};
    rows[17] = '{'{18'sd1, 18'sd80000, 18'sd2, 1'b1}, 1'b0, '0};
    rows[18] = '{'{18'sd100, 18'sd200, 18'sd300, 1'b0}, 1'b0, '0};
    rows[19] = '{'{18'sd400, 18'sd20, 18'sd9, 1'b0}, 1'b0, '0};
    rows[20] = '{'{18'sd7, 18'sd900, 18'sd60, 1'b0}, 1'b0, '0};
    rows[21] = '{'{18'sd3, 18'sd8, 18'sd1, 1'b1}, 1'b0, '0};

    for (int i = 0; i < N_DIR; i++) begin
      if (rows[i].chk) begin
        typed_q.push_back(rows[i].res);
        typed_v.push_back(rows[i].chk);
      end
      send(rows[i].pt);
    end
    drain();
    typed_q.delete();
    typed_v.delete();

    lims[0] = '0; lims[1] = 17'h1FFFF; lims[2] = 17'd300; lims[3] = 17'd80000;
    for (int ph = 0; ph < 4; ph++) begin
      set_maxd(lims[ph]);
      snd_idle = ph == 0 ? 11 : (ph == 1 ? 77 : 0);
      rcv_idle = ph == 0 ? 77 : (ph == 1 ? 11 : 0);
      if (ph == 2) hold_off <= 3000;
      for (int k = 0; k < 330; k += len) begin
        len = $urandom_range(1, 12);
        for (int j = 0; j < len; j++) begin
          p.x = rnd_coord(lims[ph] == 0 ? 17'd60 : lims[ph]);
          p.y = rnd_coord(lims[ph] == 0 ? 17'd60 : lims[ph]);
          p.z = rnd_coord(lims[ph] == 0 ? 17'd60 : lims[ph]);
          p.eoc = (j == len - 1) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0);
          send(p);
        end
      end
    end
    p = '0;
    p.eoc = 1'b1;
    send(p);
    drain();

    $display("Ran %0d points, %0d normals checked, over four max_distance settings.",
             n_items, n_results);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
rtl/pne_pkg.sv
rtl/pne_datapath.sv
rtl/pne_controller.sv
rtl/point_normal_estimator_unit.sv
rtl/pne_checker.sv
sim/tb.sv
